@@ hw/rtl/regalloc_pkg.sv @@
// Shared types and constants for the register allocator with spill.
package regalloc_pkg;

  localparam int unsigned MAX_VALUES = 256;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned VID_W      = 8;
  localparam int unsigned END_W      = 11;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned REG_W      = 4;
  localparam int unsigned SLOT_W     = 8;

  localparam logic [CNT_W-1:0] SPILL_MAX = 9'd511;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_ALLOC = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_ACK   = 2'd0,
    STATUS_SKIP  = 2'd1,
    STATUS_REG   = 2'd2,
    STATUS_SPILL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_FINISH
  } state_e;

endpackage

@@ hw/rtl/register_allocator_with_spill.sv @@
// Greedy first-free register allocator with spill to stack slots.
//
// Requests arrive on a valid/ready input channel (command plus operands);
// each request yields exactly one result on a valid/ready output channel.
// Start clears the busy map, the value-to-register map and the spill count
// and records the run size. Load writes one lifetime end into the lifetime
// RAM. Allocate scans the lifetime RAM and the register map RAM, one value
// per cycle, freeing registers whose value dies at this instruction, then
// hands out the lowest free register or the next stack slot.
// Sequence: start, load, skipped allocate and unknown commands go from idle
// straight to the finish state, which loads the output register; a full
// allocate passes through the scan state (one read per value, the registered
// RAM read, a final drain), then the allocate state and the finish state.
// One request is in flight at a time; in_ready_o is high only when idle.
// The result sits in an output register; if the receiver stalls, the next
// finished result waits until that register is taken.
// Reset frees all registers, clears the map and counters; the lifetime RAM
// is not cleared and must be loaded before it is scanned.
module register_allocator_with_spill #(
  parameter int unsigned NUM_REGISTERS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [regalloc_pkg::CMD_W-1:0]       command_i,
  input  logic [regalloc_pkg::CNT_W-1:0]       value_count_i,
  input  logic [regalloc_pkg::VID_W-1:0]       value_id_i,
  input  logic signed [regalloc_pkg::END_W-1:0] lifetime_end_i,
  input  logic [regalloc_pkg::IDX_W-1:0]       instr_index_i,
  input  logic                                 no_allocate_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic [regalloc_pkg::REG_W-1:0]       register_number_o,
  output logic [regalloc_pkg::SLOT_W-1:0]      slot_number_o,
  output logic [regalloc_pkg::CNT_W-1:0]       slots_used_o
);

  localparam int unsigned CNT_W  = regalloc_pkg::CNT_W;
  localparam int unsigned VID_W  = regalloc_pkg::VID_W;
  localparam int unsigned END_W  = regalloc_pkg::END_W;
  localparam int unsigned IDX_W  = regalloc_pkg::IDX_W;
  localparam int unsigned REG_W  = regalloc_pkg::REG_W;
  localparam int unsigned SLOT_W = regalloc_pkg::SLOT_W;
  localparam int unsigned NV     = regalloc_pkg::MAX_VALUES;

  regalloc_pkg::state_e  state_q, state_d;
  regalloc_pkg::cmd_e    cmd;
  regalloc_pkg::status_e status_q, status_d, out_status_q;

  logic [NUM_REGISTERS-1:0] busy_q, busy_d;
  logic [NV-1:0]            map_vld_q, map_vld_d;
  logic [CNT_W-1:0]         spill_q, spill_d;
  logic [CNT_W-1:0]         vir_q, vir_d;
  logic [CNT_W-1:0]         scan_q, scan_d;
  logic                     rd_pend_q, rd_pend_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [VID_W-1:0]         vid_q, vid_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [REG_W-1:0]         regnum_q, regnum_d, out_regnum_q;
  logic [SLOT_W-1:0]        slot_q, slot_d, out_slot_q;
  logic [CNT_W-1:0]         out_used_q;
  logic                     out_valid_q, out_valid_d;
  logic                     out_load;

  logic                     in_accept;
  logic                     skip;
  logic                     lt_we;
  logic                     map_we;
  logic [END_W-1:0]         lt_rdata;
  logic [REG_W-1:0]         map_rdata;
  logic                     hit;
  logic                     free_found;
  logic [REG_W-1:0]         free_reg;

  assign in_ready_o = (state_q == regalloc_pkg::S_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign cmd        = regalloc_pkg::cmd_e'(command_i);
  assign lt_we      = in_accept && (cmd == regalloc_pkg::CMD_LOAD);

  assign skip = (lifetime_end_i == {END_W{1'b1}}) || no_allocate_i ||
                ({1'b0, value_id_i} >= vir_q);

  regalloc_ram #(
    .WIDTH (END_W),
    .DEPTH (NV)
  ) u_lt_ram (
    .clk_i   (clk_i),
    .we_i    (lt_we),
    .waddr_i (value_id_i),
    .wdata_i (lifetime_end_i),
    .raddr_i (scan_q[VID_W-1:0]),
    .rdata_o (lt_rdata)
  );

  regalloc_ram #(
    .WIDTH (REG_W),
    .DEPTH (NV)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (vid_q),
    .wdata_i (free_reg),
    .raddr_i (scan_q[VID_W-1:0]),
    .rdata_o (map_rdata)
  );

  // A value dies here when its lifetime end is non-negative and equals the index.
  assign hit = rd_pend_q && rd_vld_q && !lt_rdata[END_W-1] &&
               (lt_rdata[IDX_W-1:0] == idx_q) &&
               (map_rdata < REG_W'(NUM_REGISTERS));

  always_comb begin
    free_found = 1'b0;
    free_reg   = '0;
    for (int r = NUM_REGISTERS - 1; r >= 0; r--) begin
      if (!busy_q[r]) begin
        free_found = 1'b1;
        free_reg   = REG_W'(r);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    busy_d    = busy_q;
    map_vld_d = map_vld_q;
    spill_d   = spill_q;
    vir_d     = vir_q;
    scan_d    = scan_q;
    rd_pend_d = 1'b0;
    rd_vld_d  = 1'b0;
    vid_d     = vid_q;
    idx_d     = idx_q;
    status_d  = status_q;
    regnum_d  = regnum_q;
    slot_d    = slot_q;
    map_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      regalloc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          regnum_d = '0;
          slot_d   = '0;
          status_d = regalloc_pkg::STATUS_ACK;
          state_d  = regalloc_pkg::S_FINISH;
          case (cmd)
            regalloc_pkg::CMD_START: begin
              busy_d    = '0;
              map_vld_d = '0;
              spill_d   = '0;
              vir_d     = (value_count_i > CNT_W'(NV)) ? CNT_W'(NV) : value_count_i;
            end
            regalloc_pkg::CMD_LOAD: begin
            end
            regalloc_pkg::CMD_ALLOC: begin
              if (skip) begin
                status_d = regalloc_pkg::STATUS_SKIP;
              end else begin
                vid_d   = value_id_i;
                idx_d   = instr_index_i;
                scan_d  = '0;
                state_d = regalloc_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      regalloc_pkg::S_SCAN: begin
        // Read issued this cycle is consumed next cycle; no map writes occur
        // during the scan, so no forwarding is needed.
        rd_pend_d = (scan_q < vir_q);
        rd_vld_d  = map_vld_q[scan_q[VID_W-1:0]];
        if (scan_q < vir_q) begin
          scan_d = scan_q + CNT_W'(1);
        end
        if (hit) begin
          busy_d = busy_q & ~(NUM_REGISTERS'(1) << map_rdata);
        end
        if ((scan_q == vir_q) && !rd_pend_q) begin
          state_d = regalloc_pkg::S_ALLOC;
        end
      end
      regalloc_pkg::S_ALLOC: begin
        if (free_found) begin
          busy_d           = busy_q | (NUM_REGISTERS'(1) << free_reg);
          map_we           = 1'b1;
          map_vld_d[vid_q] = 1'b1;
          status_d         = regalloc_pkg::STATUS_REG;
          regnum_d         = free_reg;
        end else begin
          status_d = regalloc_pkg::STATUS_SPILL;
          slot_d   = spill_q[SLOT_W-1:0];
          if (spill_q < regalloc_pkg::SPILL_MAX) begin
            spill_d = spill_q + CNT_W'(1);
          end
        end
        state_d = regalloc_pkg::S_FINISH;
      end
      regalloc_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = regalloc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = regalloc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= regalloc_pkg::S_IDLE;
      busy_q      <= '0;
      map_vld_q   <= '0;
      spill_q     <= '0;
      vir_q       <= '0;
      scan_q      <= '0;
      rd_pend_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= busy_d;
      map_vld_q   <= map_vld_d;
      spill_q     <= spill_d;
      vir_q       <= vir_d;
      scan_q      <= scan_d;
      rd_pend_q   <= rd_pend_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vid_q    <= vid_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    regnum_q <= regnum_d;
    slot_q   <= slot_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_regnum_q <= regnum_q;
      out_slot_q   <= slot_q;
      out_used_q   <= spill_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign register_number_o = out_regnum_q;
  assign slot_number_o     = out_slot_q;
  assign slots_used_o      = out_used_q;

endmodule

@@ hw/rtl/regalloc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module regalloc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/register_allocator_with_spill_tb.sv @@
// Testbench: register allocator with spill, checked against a cycle-free predictor.
`timescale 1ns / 100ps

module register_allocator_with_spill_tb;

  localparam int unsigned CMD_W      = regalloc_pkg::CMD_W;
  localparam int unsigned CNT_W      = regalloc_pkg::CNT_W;
  localparam int unsigned VID_W      = regalloc_pkg::VID_W;
  localparam int unsigned END_W      = regalloc_pkg::END_W;
  localparam int unsigned IDX_W      = regalloc_pkg::IDX_W;
  localparam int unsigned REG_W      = regalloc_pkg::REG_W;
  localparam int unsigned SLOT_W     = regalloc_pkg::SLOT_W;
  localparam int unsigned MAX_VALUES = regalloc_pkg::MAX_VALUES;
  localparam logic [CNT_W-1:0] SPILL_MAX = regalloc_pkg::SPILL_MAX;

  localparam int NUM_REGS = 12;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [REG_W-1:0] REG_NONE = 4'd15;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    regalloc_pkg::status_e status;
    logic [REG_W-1:0]      reg_num;
    logic [SLOT_W-1:0]     slot;
    logic [CNT_W-1:0]      used;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [CMD_W-1:0] command_i;
  logic [CNT_W-1:0] value_count_i;
  logic [VID_W-1:0] value_id_i;
  logic signed [END_W-1:0] lifetime_end_i;
  logic [IDX_W-1:0] instr_index_i;
  logic no_allocate_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [REG_W-1:0] register_number_o;
  logic [SLOT_W-1:0] slot_number_o;
  logic [CNT_W-1:0] slots_used_o;

  // predictor state
  logic [NUM_REGS-1:0] busy_map;
  logic signed [END_W-1:0] end_table [MAX_VALUES];
  logic [REG_W-1:0] reg_map [MAX_VALUES];
  bit end_written [MAX_VALUES];
  logic [CNT_W-1:0] spill_count;
  logic [CNT_W-1:0] run_size;

  outcome_t pending_outcomes [$];
  outcome_t want;
  bit no_idle = 1'b0;
  int n_requests = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_grants = 0;
  int n_spills = 0;
  int n_full_runs = 0;
  int idle_cycles;

  register_allocator_with_spill #(.NUM_REGISTERS(NUM_REGS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .value_count_i,
    .value_id_i, .lifetime_end_i, .instr_index_i, .no_allocate_i,
    .out_valid_o, .out_ready_i, .status_o, .register_number_o,
    .slot_number_o, .slots_used_o
  );

  initial forever #6 clk_i = ~clk_i;

  function automatic bit scan_is_safe();
    for (int p = 0; p < run_size; p++) begin
      if (!end_written[p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [END_W-1:0] any_end();
    int v;
    v = $urandom_range(0, 1024);
    return END_W'(v - 1);
  endfunction

  function automatic outcome_t predict_outcome(
      logic [CMD_W-1:0] cmd, logic [CNT_W-1:0] count, logic [VID_W-1:0] vid,
      logic signed [END_W-1:0] life_end, logic [IDX_W-1:0] idx, logic noalloc);
    outcome_t o;
    int r;
    o = '{status: regalloc_pkg::STATUS_ACK, reg_num: '0, slot: '0, used: '0};
    case (cmd)
      regalloc_pkg::CMD_START: begin
        busy_map = '0;
        foreach (reg_map[k]) reg_map[k] = REG_NONE;
        spill_count = '0;
        run_size = (count > MAX_VALUES) ? CNT_W'(MAX_VALUES) : count;
      end
      regalloc_pkg::CMD_LOAD: begin
        end_table[vid] = life_end;
        end_written[vid] = 1'b1;
      end
      regalloc_pkg::CMD_ALLOC: begin
        if (life_end == -11'sd1 || noalloc || {1'b0, vid} >= run_size) begin
          o.status = regalloc_pkg::STATUS_SKIP;
        end else begin
          // free every register whose value dies at this instruction
          for (int p = 0; p < run_size; p++) begin
            if (int'(end_table[p]) == int'(idx) && reg_map[p] < NUM_REGS)
              busy_map[reg_map[p]] = 1'b0;
          end
          r = 0;
          while (r < NUM_REGS && busy_map[r]) r++;
          if (r < NUM_REGS) begin
            busy_map[r] = 1'b1;
            reg_map[vid] = REG_W'(r);
            o.status = regalloc_pkg::STATUS_REG;
            o.reg_num = REG_W'(r);
            n_grants++;
          end else begin
            o.status = regalloc_pkg::STATUS_SPILL;
            o.slot = spill_count[SLOT_W-1:0];
            if (spill_count < SPILL_MAX) spill_count++;
            n_spills++;
          end
        end
      end
      default: ;
    endcase
    o.used = spill_count;
    return o;
  endfunction

  task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] count,
      input logic [VID_W-1:0] vid, input logic signed [END_W-1:0] life_end,
      input logic [IDX_W-1:0] idx, input logic noalloc);
    int gap;
    logic na;
    na = noalloc;
    // never let the block scan a lifetime entry that was never loaded
    if (cmd == regalloc_pkg::CMD_ALLOC && life_end != -11'sd1 && !noalloc &&
        {1'b0, vid} < run_size && !scan_is_safe())
      na = 1'b1;
    gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    repeat (gap) @(negedge clk_i);
    command_i <= cmd;
    value_count_i <= count;
    value_id_i <= vid;
    lifetime_end_i <= life_end;
    instr_index_i <= idx;
    no_allocate_i <= na;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_outcomes.push_back(predict_outcome(cmd, count, vid, life_end, idx, na));
    n_requests++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // one block: start, lifetime loads (only some if broken), then allocates with non-increasing index
  task automatic run_block(input int n, input int allocs, input bit broken);
    int top, lo, nload, pick, idx;
    logic signed [END_W-1:0] le;
    logic [VID_W-1:0] vid;
    top = $urandom_range(allocs, 1023);
    lo = top - allocs;
    issue_request(regalloc_pkg::CMD_START, CNT_W'(n), VID_W'($urandom), any_end(),
                  IDX_W'($urandom), 1'($urandom));
    nload = broken ? $urandom_range(0, n - 1) : n;
    for (int v = 0; v < nload; v++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) le = -11'sd1;
      else if (pick == 1) le = END_W'($urandom_range(0, 1023));
      else le = END_W'($urandom_range(lo, top));
      issue_request(regalloc_pkg::CMD_LOAD, CNT_W'($urandom_range(0, 256)), VID_W'(v), le,
                    IDX_W'($urandom), 1'($urandom));
    end
    if (n == MAX_VALUES)
      issue_request(regalloc_pkg::CMD_ALLOC, '0, 8'd255, END_W'($urandom_range(0, 1023)),
                    IDX_W'(top), 1'b0);
    for (int k = 0; k < allocs; k++) begin
      idx = top - k;
      vid = ($urandom_range(0, 9) != 0) ? VID_W'($urandom_range(0, n - 1))
                                        : VID_W'($urandom);
      le = ($urandom_range(0, 11) == 0) ? -11'sd1 : END_W'($urandom_range(0, 1023));
      issue_request(regalloc_pkg::CMD_ALLOC, CNT_W'($urandom_range(0, 256)), vid, le,
                    IDX_W'(idx), ($urandom_range(0, 9) == 0));
    end
  endtask

  task automatic test_directed_cases();
    issue_request(regalloc_pkg::CMD_START, 9'd0, 8'd0, 11'sd0, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd0, 11'sd5, 10'd5, 1'b0);    // empty run
    issue_request(regalloc_pkg::CMD_START, 9'd511, 8'd0, 11'sd0, 10'd0, 1'b0);  // saturates
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd10, -11'sd1, 10'd3, 1'b0);  // never live
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd10, 11'sd3, 10'd3, 1'b1);   // marker
    issue_request(CMD_UNKNOWN, 9'd17, 8'd3, 11'sd4, 10'd9, 1'b0);
    issue_request(regalloc_pkg::CMD_LOAD, 9'd0, 8'd255, 11'sd1023, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_LOAD, 9'd0, 8'd255, -11'sd1, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_START, 9'd300, 8'd0, 11'sd0, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_START, 9'd4, 8'd0, 11'sd0, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_LOAD, 9'd0, 8'd0, 11'sd1023, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_LOAD, 9'd0, 8'd1, 11'sd0, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_LOAD, 9'd0, 8'd2, -11'sd1, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_LOAD, 9'd0, 8'd3, 11'sd512, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd0, 11'sd1023, 10'd1023, 1'b0);
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd1, 11'sd0, 10'd1023, 1'b0); // reuse
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd2, 11'sd7, 10'd512, 1'b0);
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd3, 11'sd512, 10'd512, 1'b0);
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd1, 11'sd1, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd4, 11'sd9, 10'd0, 1'b0);    // id past run
    issue_request(regalloc_pkg::CMD_ALLOC, 9'd0, 8'd0, 11'sd0, 10'd0, 1'b1);
    issue_request(CMD_UNKNOWN, 9'd511, 8'd255, -11'sd1, 10'd1023, 1'b1);
  endtask

  // one live value that never dies: fill all registers, then spill past saturation
  task automatic test_spill_saturation();
    issue_request(regalloc_pkg::CMD_START, 9'd1, 8'd0, 11'sd0, 10'd0, 1'b0);
    issue_request(regalloc_pkg::CMD_LOAD, 9'd0, 8'd0, 11'sd1023, 10'd0, 1'b0);
    repeat (NUM_REGS + 520)
      issue_request(regalloc_pkg::CMD_ALLOC, CNT_W'($urandom_range(0, 256)), 8'd0,
                    END_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1022)), 1'b0);
  endtask

  task automatic test_random_runs();
    int n;
    while (n_requests < 1550) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) begin
        // noise: arbitrary commands, including broken run setups
        repeat ($urandom_range(1, 6))
          issue_request(CMD_W'($urandom), CNT_W'($urandom_range(0, 256)), VID_W'($urandom),
                        any_end(), IDX_W'($urandom), 1'($urandom));
      end else begin
        if (n_full_runs < 2 && $urandom_range(0, 19) == 0) begin
          n = MAX_VALUES;
          n_full_runs++;
        end else if ($urandom_range(0, 9) == 0) begin
          n = $urandom_range(17, 64);
        end else begin
          n = $urandom_range(1, 16);
        end
        run_block(n, (n == MAX_VALUES) ? 24 : $urandom_range(n, 3 * n),
                  ($urandom_range(0, 7) == 0));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    while (n_requests < 1750) begin
      run_block($urandom_range(1, 16), $urandom_range(8, 30), 1'b0);
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    command_i = regalloc_pkg::CMD_START;
    value_count_i = '0;
    value_id_i = '0;
    lifetime_end_i = '0;
    instr_index_i = '0;
    no_allocate_i = 1'b0;
    rst_ni = 1'b0;
    busy_map = '0;
    foreach (reg_map[k]) reg_map[k] = REG_NONE;
    foreach (end_written[k]) end_written[k] = 1'b0;
    spill_count = '0;
    run_size = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_spill_saturation();
    test_random_runs();
    test_steady_stream();

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             n_requests, n_checked, n_errors);
    $display("%0d register grants, %0d spills, %0d full-size runs",
             n_grants, n_spills, n_full_runs);
    if (n_errors == 0) begin
      $display("register_allocator_with_spill_tb: done, clean");
    end else begin
      $display("register_allocator_with_spill_tb: done, errors");
    end
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && !no_idle && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no request pending: status %0d", status_o);
        n_errors++;
      end else begin
        want = pending_outcomes.pop_front();
        n_checked++;
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          n_errors++;
        end
        if (register_number_o !== want.reg_num) begin
          $error("register_number: expected %0d, got %0d", want.reg_num, register_number_o);
          n_errors++;
        end
        if (slot_number_o !== want.slot) begin
          $error("slot_number: expected %0d, got %0d", want.slot, slot_number_o);
          n_errors++;
        end
        if (slots_used_o !== want.used) begin
          $error("slots_used: expected %0d, got %0d", want.used, slots_used_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("register_allocator_with_spill_tb: done, errors");
    $finish;
  end

endmodule

@@ register_allocator_with_spill.f @@
hw/rtl/regalloc_pkg.sv
hw/rtl/regalloc_ram.sv
hw/rtl/register_allocator_with_spill.sv
tb/register_allocator_with_spill_tb.sv
